>>> hw/rtl/tod_pkg.sv
`timescale 1ns / 1ps

package tod_pkg;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [6:0] MAX_HOUR   = 7'd23;
	localparam logic [6:0] MAX_MINSEC = 7'd59;
	localparam logic [3:0] MAX_FRAC   = 4'd9;

	typedef enum logic [11:0] {
		PH_H1        = 12'b0000_0000_0001,
		PH_H2        = 12'b0000_0000_0010,
		PH_COLON1    = 12'b0000_0000_0100,
		PH_M1        = 12'b0000_0000_1000,
		PH_M2        = 12'b0000_0001_0000,
		PH_AFTER_MIN = 12'b0000_0010_0000,
		PH_S1        = 12'b0000_0100_0000,
		PH_S2        = 12'b0000_1000_0000,
		PH_AFTER_SEC = 12'b0001_0000_0000,
		PH_FRAC1     = 12'b0010_0000_0000,
		PH_FRACN     = 12'b0100_0000_0000,
		PH_AFTER_LF  = 12'b1000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_t;

	typedef struct packed {
		logic        valid_res;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [29:0] nanosecond;
	} res_t;

	// weight of the next fraction digit, given the digits already taken
	function automatic logic [26:0] frac_weight(input logic [3:0] k);
		logic [26:0] w;
		case (k)
			4'd0:    w = 27'd100000000;
			4'd1:    w = 27'd10000000;
			4'd2:    w = 27'd1000000;
			4'd3:    w = 27'd100000;
			4'd4:    w = 27'd10000;
			4'd5:    w = 27'd1000;
			4'd6:    w = 27'd100;
			4'd7:    w = 27'd10;
			4'd8:    w = 27'd1;
			default: w = 27'd0;
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/tod_in_if.sv
`timescale 1ns / 1ps

interface tod_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source(output valid, ch, last, input ready);
	modport sink(input valid, ch, last, output ready);
endinterface

>>> hw/rtl/tod_out_if.sv
`timescale 1ns / 1ps

interface tod_out_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [29:0] nanosecond;

	modport source(output valid, valid_res, hour, minute, second, nanosecond, input ready);
	modport sink(input valid, valid_res, hour, minute, second, nanosecond, output ready);
endinterface

>>> hw/rtl/iso_time_of_day_parser.sv
`timescale 1ns / 1ps
// The verdict is loaded into the result register when the character marked last advances
// out of the input register (parse between the input register and the result register).
// Throughput: one character per cycle; the parse state updates once per character.
// A full result register stalls only characters marked last.
// Reset (arst_n low) empties both registers and returns the parser to the first hour digit.

module iso_time_of_day_parser (
	input  logic clk,
	input  logic arst_n,
	tod_in_if.sink    chars,
	tod_out_if.source verdict
);
	import tod_pkg::*;

	logic  valid_s1;
	char_t chr_s1;
	logic  res_valid_q;
	res_t  res_q;
	res_t  res;
	logic  out_free;
	logic  adv;

	assign out_free    = !res_valid_q || verdict.ready;
	assign adv         = valid_s1 && (!chr_s1.last || out_free);
	assign chars.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			chr_s1.ch   <= chars.ch;
			chr_s1.last <= chars.last;
		end
	end

	tod_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.chr    (chr_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && chr_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && chr_s1.last) begin
			res_q <= res;
		end
	end

	assign verdict.valid      = res_valid_q;
	assign verdict.valid_res  = res_q.valid_res;
	assign verdict.hour       = res_q.hour;
	assign verdict.minute     = res_q.minute;
	assign verdict.second     = res_q.second;
	assign verdict.nanosecond = res_q.nanosecond;

endmodule

>>> hw/rtl/tod_parse.sv
`timescale 1ns / 1ps

module tod_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tod_pkg::char_t chr,
	output tod_pkg::res_t res
);
	import tod_pkg::*;

	phase_t      phase_q, phase_n;
	logic        failed_q, failed_n;
	logic [6:0]  hour_q, hour_n;
	logic [6:0]  minute_q, minute_n;
	logic [6:0]  second_q, second_n;
	logic [29:0] nano_q, nano_n;
	logic [3:0]  digits_q, digits_n;

	logic        dig;
	logic        lf;
	logic [3:0]  d;
	logic [6:0]  d_x10;
	logic [30:0] prod;
	logic        ok;

	assign dig   = (chr.ch >= CH_ZERO) && (chr.ch <= CH_NINE);
	assign lf    = (chr.ch == CH_LF);
	assign d     = dig ? chr.ch[3:0] : 4'd0;
	assign d_x10 = {d, 3'b000} + {2'b00, d, 1'b0};
	assign prod  = 31'(d) * 31'(frac_weight(digits_q));

	always_comb begin
		phase_n  = phase_q;
		failed_n = failed_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		nano_n   = nano_q;
		digits_n = digits_q;
		if (!failed_q) begin
			case (phase_q)
				PH_H1: begin
					if (dig) begin
						hour_n  = d_x10;
						phase_n = PH_H2;
					end else failed_n = 1'b1;
				end
				PH_H2: begin
					if (dig) begin
						hour_n  = hour_q + 7'(d);
						phase_n = PH_COLON1;
					end else failed_n = 1'b1;
				end
				PH_COLON1: begin
					if (chr.ch == CH_COLON) phase_n = PH_M1;
					else failed_n = 1'b1;
				end
				PH_M1: begin
					if (dig) begin
						minute_n = d_x10;
						phase_n  = PH_M2;
					end else failed_n = 1'b1;
				end
				PH_M2: begin
					if (dig) begin
						minute_n = minute_q + 7'(d);
						phase_n  = PH_AFTER_MIN;
					end else failed_n = 1'b1;
				end
				PH_AFTER_MIN: begin
					if (chr.ch == CH_COLON) phase_n = PH_S1;
					else if (lf) phase_n = PH_AFTER_LF;
					else failed_n = 1'b1;
				end
				PH_S1: begin
					if (dig) begin
						second_n = d_x10;
						phase_n  = PH_S2;
					end else failed_n = 1'b1;
				end
				PH_S2: begin
					if (dig) begin
						second_n = second_q + 7'(d);
						phase_n  = PH_AFTER_SEC;
					end else failed_n = 1'b1;
				end
				PH_AFTER_SEC: begin
					if (chr.ch == CH_DOT) phase_n = PH_FRAC1;
					else if (lf) phase_n = PH_AFTER_LF;
					else failed_n = 1'b1;
				end
				PH_FRAC1: begin
					if (dig) begin
						nano_n   = prod[29:0];
						digits_n = 4'd1;
						phase_n  = PH_FRACN;
					end else failed_n = 1'b1;
				end
				PH_FRACN: begin
					if (dig && (digits_q < MAX_FRAC)) begin
						nano_n   = nano_q + prod[29:0];
						digits_n = digits_q + 4'd1;
					end else if (lf) begin
						phase_n = PH_AFTER_LF;
					end else failed_n = 1'b1;
				end
				default: failed_n = 1'b1;
			endcase
		end
	end

	always_comb begin
		ok = !failed_n
			&& ((phase_n == PH_AFTER_MIN) || (phase_n == PH_AFTER_SEC)
				|| (phase_n == PH_FRACN) || (phase_n == PH_AFTER_LF))
			&& (hour_n <= MAX_HOUR) && (minute_n <= MAX_MINSEC)
			&& (second_n <= MAX_MINSEC);
		if (ok) begin
			res.valid_res  = 1'b1;
			res.hour       = hour_n[4:0];
			res.minute     = minute_n[5:0];
			res.second     = second_n[5:0];
			res.nanosecond = nano_n;
		end else begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_H1;
			failed_q <= 1'b0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			nano_q   <= '0;
			digits_q <= '0;
		end else if (en) begin
			if (chr.last) begin
				phase_q  <= PH_H1;
				failed_q <= 1'b0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				nano_q   <= '0;
				digits_q <= '0;
			end else begin
				phase_q  <= phase_n;
				failed_q <= failed_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
				nano_q   <= nano_n;
				digits_q <= digits_n;
			end
		end
	end

endmodule

>>> tb/tod_verdict_checker.sv
`timescale 1ns / 1ps

module tod_verdict_checker (
	input  logic        clk,
	input  logic        arst_n,
	tod_in_if           chars,
	tod_out_if          verdict,
	output int unsigned mismatches,
	output int unsigned pending
);
	import tod_pkg::*;

	localparam int unsigned REPORT_LIMIT = 10;
	localparam longint unsigned NANO_CEIL = 64'd999999999;

	phase_t      ph;
	logic        failed;
	logic [6:0]  hour_acc;
	logic [6:0]  minute_acc;
	logic [6:0]  second_acc;
	logic [29:0] frac_acc;
	logic [3:0]  frac_cnt;

	res_t        verdict_q[$];
	res_t        got;
	res_t        want;
	int unsigned fail_count;

	task automatic clear_parse();
		ph         = PH_H1;
		failed     = 1'b0;
		hour_acc   = '0;
		minute_acc = '0;
		second_acc = '0;
		frac_acc   = '0;
		frac_cnt   = '0;
	endtask

	task automatic report(input string what, input res_t exp_r, input res_t act_r);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%t %s: expected %0b %0d:%0d:%0d.%0d, got %0b %0d:%0d:%0d.%0d",
				$realtime, what,
				exp_r.valid_res, exp_r.hour, exp_r.minute, exp_r.second, exp_r.nanosecond,
				act_r.valid_res, act_r.hour, act_r.minute, act_r.second, act_r.nanosecond);
	endtask

	task automatic digest_char(input logic [7:0] c, input logic fin);
		logic            dig;
		logic [3:0]      d;
		logic            lf;
		logic            ok;
		longint unsigned scale;
		longint unsigned nano;
		int              k;
		res_t            r;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		d   = dig ? 4'(c - CH_ZERO) : 4'd0;
		lf  = (c == CH_LF);
		if (!failed) begin
			case (ph)
				PH_H1: begin
					if (dig) begin
						hour_acc = 7'(d * 10);
						ph = PH_H2;
					end else failed = 1'b1;
				end
				PH_H2: begin
					if (dig) begin
						hour_acc = hour_acc + 7'(d);
						ph = PH_COLON1;
					end else failed = 1'b1;
				end
				PH_COLON1: begin
					if (c == CH_COLON) ph = PH_M1;
					else failed = 1'b1;
				end
				PH_M1: begin
					if (dig) begin
						minute_acc = 7'(d * 10);
						ph = PH_M2;
					end else failed = 1'b1;
				end
				PH_M2: begin
					if (dig) begin
						minute_acc = minute_acc + 7'(d);
						ph = PH_AFTER_MIN;
					end else failed = 1'b1;
				end
				PH_AFTER_MIN: begin
					if (c == CH_COLON) ph = PH_S1;
					else if (lf) ph = PH_AFTER_LF;
					else failed = 1'b1;
				end
				PH_S1: begin
					if (dig) begin
						second_acc = 7'(d * 10);
						ph = PH_S2;
					end else failed = 1'b1;
				end
				PH_S2: begin
					if (dig) begin
						second_acc = second_acc + 7'(d);
						ph = PH_AFTER_SEC;
					end else failed = 1'b1;
				end
				PH_AFTER_SEC: begin
					if (c == CH_DOT) ph = PH_FRAC1;
					else if (lf) ph = PH_AFTER_LF;
					else failed = 1'b1;
				end
				PH_FRAC1: begin
					if (dig) begin
						frac_acc = 30'(d);
						frac_cnt = 4'd1;
						ph = PH_FRACN;
					end else failed = 1'b1;
				end
				PH_FRACN: begin
					if (dig && frac_cnt < MAX_FRAC) begin
						frac_acc = 30'(frac_acc * 10 + d);
						frac_cnt = frac_cnt + 4'd1;
					end else if (lf) ph = PH_AFTER_LF;
					else failed = 1'b1;
				end
				default: failed = 1'b1;
			endcase
		end
		if (fin) begin
			ok = !failed &&
				(ph == PH_AFTER_MIN || ph == PH_AFTER_SEC || ph == PH_FRACN ||
				ph == PH_AFTER_LF) &&
				hour_acc <= MAX_HOUR && minute_acc <= MAX_MINSEC &&
				second_acc <= MAX_MINSEC;
			nano = 0;
			if (ok && frac_cnt >= 1 && frac_cnt <= MAX_FRAC) begin
				scale = 1;
				for (k = frac_cnt; k < MAX_FRAC; k++)
					scale = scale * 10;
				nano = frac_acc * scale;
				if (nano > NANO_CEIL)
					ok = 1'b0;
			end
			r = '0;
			if (ok) begin
				r.valid_res  = 1'b1;
				r.hour       = hour_acc[4:0];
				r.minute     = minute_acc[5:0];
				r.second     = second_acc[5:0];
				r.nanosecond = nano[29:0];
			end
			verdict_q.push_back(r);
			clear_parse();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			verdict_q.delete();
			fail_count = 0;
		end else begin
			if (verdict.valid && verdict.ready) begin
				got.valid_res  = verdict.valid_res;
				got.hour       = verdict.hour;
				got.minute     = verdict.minute;
				got.second     = verdict.second;
				got.nanosecond = verdict.nanosecond;
				if (verdict_q.size() == 0) begin
					report("unexpected verdict", '0, got);
				end else begin
					want = verdict_q.pop_front();
					if (got !== want)
						report("verdict mismatch", want, got);
				end
			end
			if (chars.valid && chars.ready)
				digest_char(chars.ch, chars.last);
		end
		mismatches <= fail_count;
		pending    <= verdict_q.size();
	end

endmodule

>>> tb/iso_time_of_day_parser_test.sv
`timescale 1ns / 1ps

module iso_time_of_day_parser_test;
	import tod_pkg::*;

	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned CHARS_PER_RUN = 250;

	logic        clk;
	logic        arst_n;
	int unsigned send_idle;
	int unsigned recv_idle;
	int unsigned mismatches;
	int unsigned pending_verdicts;
	int unsigned idle_cycles;
	int unsigned chars_sent;
	logic [7:0]  text_q[$];

	tod_in_if  chars_if ();
	tod_out_if verdict_if ();

	iso_time_of_day_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.verdict (verdict_if)
	);

	tod_verdict_checker verdict_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars_if),
		.verdict    (verdict_if),
		.mismatches (mismatches),
		.pending    (pending_verdicts)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		verdict_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			verdict_if.ready = ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((chars_if.valid && chars_if.ready) || (verdict_if.valid && verdict_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [7:0] digit_char(input int unsigned top);
		return CH_ZERO + 8'($urandom_range(top));
	endfunction

	task automatic push_char(input logic [7:0] c, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			chars_if.valid = 1'b0;
			chars_if.ch    = 8'($urandom_range(255));
			chars_if.last  = 1'($urandom_range(1));
			@(negedge clk);
		end
		chars_if.valid = 1'b1;
		chars_if.ch    = c;
		chars_if.last  = fin;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		int i;
		for (i = 0; i < text_q.size(); i++)
			push_char(text_q[i], i == text_q.size() - 1);
	endtask

	task automatic send_string(input string s);
		int i;
		text_q.delete();
		for (i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		send_text();
	endtask

	task automatic compose_text();
		int unsigned kind;
		int unsigned n;
		int unsigned pos;
		int unsigned i;
		text_q.delete();
		kind = $urandom_range(99);
		if (kind < 12) begin
			n = $urandom_range(1, 8);
			repeat (n) text_q.push_back(8'($urandom_range(255)));
			return;
		end
		text_q.push_back(digit_char(($urandom_range(9) == 0) ? 9 : 2));
		text_q.push_back(digit_char(9));
		text_q.push_back(CH_COLON);
		text_q.push_back(digit_char(($urandom_range(7) == 0) ? 9 : 5));
		text_q.push_back(digit_char(9));
		if ($urandom_range(99) < 60) begin
			text_q.push_back(CH_COLON);
			text_q.push_back(digit_char(($urandom_range(7) == 0) ? 9 : 5));
			text_q.push_back(digit_char(9));
			if ($urandom_range(99) < 55) begin
				text_q.push_back(CH_DOT);
				n = ($urandom_range(9) == 0) ? $urandom_range(10, 11) : $urandom_range(1, 9);
				repeat (n) text_q.push_back(digit_char(9));
			end
		end
		if ($urandom_range(99) < 30)
			text_q.push_back(CH_LF);
		if (kind >= 70) begin
			case ($urandom_range(2))
				0: begin
					pos = $urandom_range(text_q.size() - 1);
					text_q[pos] = 8'($urandom_range(255));
				end
				1: begin
					n = $urandom_range(1, text_q.size());
					while (text_q.size() > n)
						void'(text_q.pop_back());
				end
				default: begin
					n = $urandom_range(1, 3);
					for (i = 0; i < n; i++) begin
						case ($urandom_range(4))
							0: text_q.push_back(CH_COLON);
							1: text_q.push_back(CH_DOT);
							2: text_q.push_back(CH_LF);
							3: text_q.push_back(digit_char(9));
							default: text_q.push_back(8'($urandom_range(255)));
						endcase
					end
				end
			endcase
		end
	endtask

	initial begin
		int phase_no;
		arst_n         = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.ch    = '0;
		chars_if.last  = 1'b0;
		send_idle      = 0;
		recv_idle      = 0;
		chars_sent     = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (phase_no = 0; phase_no < 3; phase_no++) begin
			case (phase_no)
				0: begin
					send_idle = 14;
					recv_idle = 71;
				end
				1: begin
					send_idle = 71;
					recv_idle = 14;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			chars_sent = 0;
			if (phase_no == 0) begin
				send_string("23:59:59.999999999");
				text_q.delete();
				text_q.push_back(8'hFF);
				send_text();
				send_string("00:00\n");
			end
			while (chars_sent < CHARS_PER_RUN) begin
				compose_text();
				send_text();
			end
			chars_if.valid = 1'b0;
			wait (pending_verdicts == 0);
			@(negedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_verdicts == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
